>>> hdl/psa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_pkg: shared definitions of the polynomial square root unit
// Status codes, fixed-point constants and the coefficient table.
// ----------------------------------------------------------------------------
package psa_pkg;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NAN    = 2'd2,
    ST_INF    = 2'd3
  } status_e;

  localparam int POLY_TERMS_DEF = 10;
  localparam int POLY_TERMS_MIN = 4;
  localparam int POLY_TERMS_MAX = 16;

  // Width of the signed Q2.30 accumulator with headroom for the partial sums.
  localparam int ACC_W = 34;

  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] PINF_BITS = 32'h7F80_0000;

  // Q2.30 coefficients of the sqrt(1+m) polynomial; slots past the tenth are zero.
  function automatic logic signed [31:0] psa_coef(input logic [3:0] idx);
    logic signed [31:0] c;
    unique case (idx)
      4'd0:    c = 32'sd1073741824;
      4'd1:    c = 32'sd536870713;
      4'd2:    c = -32'sd134212111;
      4'd3:    c = 32'sd67039923;
      4'd4:    c = -32'sd41485493;
      4'd5:    c = 32'sd27518552;
      4'd6:    c = -32'sd17201518;
      4'd7:    c = 32'sd8675837;
      4'd8:    c = -32'sd2913702;
      4'd9:    c = 32'sd466224;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/psa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_in_if: operand channel
// Valid/ready channel carrying one single-precision operand per beat.
// ----------------------------------------------------------------------------
interface psa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;

  modport source (output valid, output operand_bits, input ready);
  modport sink (input valid, input operand_bits, output ready);
endinterface
`default_nettype wire

>>> hdl/psa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_out_if: result channel
// Valid/ready channel carrying one square root and its status per beat.
// ----------------------------------------------------------------------------
interface psa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] root_bits;
  logic [1:0]  status;

  modport source (output valid, output root_bits, output status, input ready);
  modport sink (input valid, input root_bits, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/poly_sqrt_approx_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poly_sqrt_approx_unit: pipelined approximate single-precision square root
// Operands arrive on in_i and results leave on out_o, one beat per item.
// The operand is decoded into (1+m)*2^e with subnormals normalized, sqrt(1+m)
// is evaluated by a fixed polynomial with one pipeline stage per term, the
// value is scaled by sqrt(2) for odd exponents, and then normalized and
// rounded to nearest even.
// An input beat passes through decode, POLY_TERMS - 1 term stages, scale,
// leading-one detect, shift/round and the output register before it leaves.
// Throughput is one beat per cycle while out_o.ready stays high; each stage
// holds one item with its own valid bit and a stage loads whenever it is
// empty or its successor moves, so bubbles close up.
// When the receiver holds out_o.ready low, the output register keeps its
// beat and the stages behind it keep filling until the pipeline is full;
// only then does in_i.ready drop. Nothing is lost or repeated.
// Reset clears all valid bits; no item is in flight afterwards.
// Zero returns the input with status 1, negative or NaN gives a quiet NaN
// with status 2 and +inf gives +inf with status 3.
// ----------------------------------------------------------------------------
module poly_sqrt_approx_unit #(
  parameter int POLY_TERMS = psa_pkg::POLY_TERMS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psa_in_if.sink    in_i,
  psa_out_if.source out_o
);
  import psa_pkg::*;

  localparam int NP = POLY_TERMS - 1;
  localparam logic [9:0] EXP_ADJ = 10'(127 - 30 - 80);

  // Decode and polynomial term stages, index 0 is the decode stage.
  logic [NP:0]              pv_q, en_p;
  logic [23:0]              m_q   [0:NP];
  logic [23:0]              p_q   [0:NP];
  logic [23:0]              p_d   [0:NP];
  logic signed [ACC_W-1:0]  acc_q [0:NP];
  logic signed [ACC_W-1:0]  acc_d [0:NP];
  logic [7:0]               hue_q [0:NP];
  logic [NP:0]              odd_q, sp_q;
  logic [31:0]              sroot_q [0:NP];
  status_e                  sstat_q [0:NP];

  logic [23:0] m0_d;
  logic [7:0]  hue0_d;
  logic        odd0_d, sp0_d;
  logic [31:0] sroot0_d;
  status_e     sstat0_d;

  // Scale stage.
  logic        sv_q, en_scl;
  logic [31:0] sv_v_q, sv_v_d;
  logic [7:0]  sv_hue_q;
  logic        sv_sp_q;
  logic [31:0] sv_sroot_q;
  status_e     sv_sstat_q;

  // Leading-one stage.
  logic        lv_q, en_lzc;
  logic [31:0] lv_v_q;
  logic [4:0]  lv_lead_q, lv_lead_d;
  logic        lv_zero_q;
  logic [7:0]  lv_hue_q;
  logic        lv_sp_q;
  logic [31:0] lv_sroot_q;
  status_e     lv_sstat_q;

  // Shift and round stage.
  logic        hv_q, en_shf;
  logic [23:0] hv_mant_q, hv_mant_d;
  logic        hv_rnd_q, hv_rnd_d;
  logic [4:0]  hv_lead_q;
  logic        hv_zero_q;
  logic [7:0]  hv_hue_q;
  logic        hv_sp_q;
  logic [31:0] hv_sroot_q;
  status_e     hv_sstat_q;

  // Output register.
  logic        ov_q, en_out;
  logic [31:0] root_q, root_d;
  status_e     stat_q, stat_d;

  // Backward enable chain: a stage loads when it is empty or its successor loads.
  always_comb begin
    en_out = !ov_q || out_o.ready;
    en_shf = !hv_q || en_out;
    en_lzc = !lv_q || en_shf;
    en_scl = !sv_q || en_lzc;
    en_p[NP] = !pv_q[NP] || en_scl;
    for (int k = NP - 1; k >= 0; k--) begin
      en_p[k] = !pv_q[k] || en_p[k + 1];
    end
  end

  assign in_i.ready = en_p[0];

  // Decode: special operands, subnormal normalization and exponent split.
  always_comb begin
    logic [31:0] x;
    logic [7:0]  ef;
    logic [22:0] fr, frn;
    logic [4:0]  lead;
    logic [8:0]  ue;
    x        = in_i.operand_bits;
    ef       = x[30:23];
    fr       = x[22:0];
    sp0_d    = 1'b0;
    sroot0_d = 32'd0;
    sstat0_d = ST_NORMAL;
    if (ef == 8'd0 && fr == 23'd0) begin
      sp0_d    = 1'b1;
      sroot0_d = x;
      sstat0_d = ST_ZERO;
    end else if ((ef == 8'hFF && fr != 23'd0) || x[31]) begin
      sp0_d    = 1'b1;
      sroot0_d = QNAN_BITS;
      sstat0_d = ST_NAN;
    end else if (ef == 8'hFF) begin
      sp0_d    = 1'b1;
      sroot0_d = PINF_BITS;
      sstat0_d = ST_INF;
    end
    lead = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) begin
        lead = 5'(i);
      end
    end
    if (ef == 8'd0) begin
      frn = 23'({9'd0, fr} << (5'd23 - lead));
      ue  = 9'(lead) + 9'd11;
    end else begin
      frn = fr;
      ue  = 9'(ef) + 9'd33;
    end
    m0_d   = {frn, 1'b0};
    hue0_d = ue[8:1];
    odd0_d = ue[0];
  end

  // One polynomial term per stage: acc += c_k * m^k, and the next power of m.
  always_comb begin
    logic signed [31:0] c;
    logic [31:0] cabs;
    logic [54:0] prod;
    logic [30:0] tmag;
    logic [47:0] pm;
    p_d[0]   = m0_d;
    acc_d[0] = ACC_W'(psa_coef(4'd0));
    for (int k = 1; k <= NP; k++) begin
      c    = psa_coef(4'(k));
      cabs = c[31] ? 32'(-c) : 32'(c);
      prod = 55'(cabs[30:0]) * 55'(p_q[k - 1]);
      tmag = 31'((prod + 55'(1 << 23)) >> 24);
      if (c[31]) begin
        acc_d[k] = acc_q[k - 1] - signed'(ACC_W'(tmag));
      end else begin
        acc_d[k] = acc_q[k - 1] + signed'(ACC_W'(tmag));
      end
      pm       = 48'(p_q[k - 1]) * 48'(m_q[k - 1]);
      p_d[k]   = 24'((pm + 48'(1 << 23)) >> 24);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      if (en_p[0]) begin
        pv_q[0] <= in_i.valid;
      end
      for (int k = 1; k <= NP; k++) begin
        if (en_p[k]) begin
          pv_q[k] <= pv_q[k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p[0]) begin
      m_q[0]     <= m0_d;
      p_q[0]     <= p_d[0];
      acc_q[0]   <= acc_d[0];
      hue_q[0]   <= hue0_d;
      odd_q[0]   <= odd0_d;
      sp_q[0]    <= sp0_d;
      sroot_q[0] <= sroot0_d;
      sstat_q[0] <= sstat0_d;
    end
    for (int k = 1; k <= NP; k++) begin
      if (en_p[k]) begin
        m_q[k]     <= m_q[k - 1];
        p_q[k]     <= p_d[k];
        acc_q[k]   <= acc_d[k];
        hue_q[k]   <= hue_q[k - 1];
        odd_q[k]   <= odd_q[k - 1];
        sp_q[k]    <= sp_q[k - 1];
        sroot_q[k] <= sroot_q[k - 1];
        sstat_q[k] <= sstat_q[k - 1];
      end
    end
  end

  // Scale: clamp the sum to [0, 2^31-1] and apply sqrt(2) for odd exponents.
  always_comb begin
    logic [30:0] v;
    logic [61:0] prod;
    if (acc_q[NP] < 0) begin
      v = 31'd0;
    end else if (acc_q[NP] > signed'(ACC_W'(32'h7FFF_FFFF))) begin
      v = 31'h7FFF_FFFF;
    end else begin
      v = acc_q[NP][30:0];
    end
    prod = 62'(v) * 62'(SQRT2_Q30);
    if (odd_q[NP]) begin
      sv_v_d = 32'((prod + 62'(1 << 29)) >> 30);
    end else begin
      sv_v_d = {1'b0, v};
    end
  end

  // Leading-one position of the scaled value.
  always_comb begin
    lv_lead_d = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (sv_v_q[i]) begin
        lv_lead_d = 5'(i);
      end
    end
  end

  // Align to 24 significant bits; the round-up bit is applied in the next stage.
  always_comb begin
    logic [4:0]  sh;
    logic [31:0] stk_mask;
    logic        guard, sticky;
    hv_rnd_d = 1'b0;
    sh       = lv_lead_q - 5'd23;
    stk_mask = (32'd1 << (sh - 5'd1)) - 32'd1;
    guard    = lv_v_q[sh - 5'd1];
    sticky   = (lv_v_q & stk_mask) != 32'd0;
    if (lv_lead_q > 5'd23) begin
      hv_mant_d = 24'(lv_v_q >> sh);
      hv_rnd_d  = guard && (sticky || hv_mant_d[0]);
    end else begin
      hv_mant_d = 24'(lv_v_q << (5'd23 - lv_lead_q));
    end
  end

  // Round, renormalize on carry-out and pack.
  always_comb begin
    logic [24:0] mant25;
    logic [23:0] mfin;
    logic [5:0]  lead6;
    logic [9:0]  be;
    mant25 = {1'b0, hv_mant_q} + 25'(hv_rnd_q);
    lead6  = {1'b0, hv_lead_q};
    if (mant25[24]) begin
      mfin  = mant25[24:1];
      lead6 = lead6 + 6'd1;
    end else begin
      mfin = mant25[23:0];
    end
    be     = 10'(lead6) + 10'(hv_hue_q) + EXP_ADJ;
    stat_d = ST_NORMAL;
    if (hv_sp_q) begin
      root_d = hv_sroot_q;
      stat_d = hv_sstat_q;
    end else if (hv_zero_q) begin
      root_d = 32'd0;
    end else if (be >= 10'd255) begin
      root_d = PINF_BITS;
    end else if (be == 10'd0) begin
      root_d = 32'd0;
    end else begin
      root_d = {1'b0, be[7:0], mfin[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      lv_q <= 1'b0;
      hv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en_scl) begin
        sv_q <= pv_q[NP];
      end
      if (en_lzc) begin
        lv_q <= sv_q;
      end
      if (en_shf) begin
        hv_q <= lv_q;
      end
      if (en_out) begin
        ov_q <= hv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_scl) begin
      sv_v_q     <= sv_v_d;
      sv_hue_q   <= hue_q[NP];
      sv_sp_q    <= sp_q[NP];
      sv_sroot_q <= sroot_q[NP];
      sv_sstat_q <= sstat_q[NP];
    end
    if (en_lzc) begin
      lv_v_q     <= sv_v_q;
      lv_lead_q  <= lv_lead_d;
      lv_zero_q  <= (sv_v_q == 32'd0);
      lv_hue_q   <= sv_hue_q;
      lv_sp_q    <= sv_sp_q;
      lv_sroot_q <= sv_sroot_q;
      lv_sstat_q <= sv_sstat_q;
    end
    if (en_shf) begin
      hv_mant_q  <= hv_mant_d;
      hv_rnd_q   <= hv_rnd_d;
      hv_lead_q  <= lv_lead_q;
      hv_zero_q  <= lv_zero_q;
      hv_hue_q   <= lv_hue_q;
      hv_sp_q    <= lv_sp_q;
      hv_sroot_q <= lv_sroot_q;
      hv_sstat_q <= lv_sstat_q;
    end
    if (en_out) begin
      root_q <= root_d;
      stat_q <= stat_d;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.root_bits = root_q;
  assign out_o.status    = stat_q;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for poly_sqrt_approx_unit
// Feeds single-precision operands through the valid/ready channels: first a
// hand-picked set of special and boundary values, then random operands,
// mostly positive normals and subnormals. Both sides idle in random bursts.
// Every accepted operand is run through a bit-exact fixed-point model of the
// polynomial square root, and each result beat is compared in order.
// ----------------------------------------------------------------------------
module tb;

  import psa_pkg::*;

  class root_scoreboard;
    typedef struct packed {
      logic [31:0] operand;
      logic [31:0] root;
      status_e     status;
    } root_expect_t;

    root_expect_t pending[$];
    longint       coef_q30[16];
    int           mismatches;

    function new();
      coef_q30 = '{64'sd1073741824, 64'sd536870713, -64'sd134212111, 64'sd67039923,
                   -64'sd41485493, 64'sd27518552, -64'sd17201518, 64'sd8675837,
                   -64'sd2913702, 64'sd466224, 64'sd0, 64'sd0,
                   64'sd0, 64'sd0, 64'sd0, 64'sd0};
      mismatches = 0;
    endfunction

    // Rounds v (Q2.30 value times 2^half_exp) to a single-precision result.
    function logic [31:0] pack_root(longint unsigned v, int half_exp);
      int lead, sh, be;
      longint unsigned rem, hv, mant;
      if (v == 0) return 32'h0;
      lead = 63;
      while (lead > 0 && !v[lead]) lead--;
      if (lead > 23) begin
        sh = lead - 23;
        rem = v & ((64'd1 << sh) - 64'd1);
        hv = 64'd1 << (sh - 1);
        mant = v >> sh;
        if (rem > hv || (rem == hv && mant[0])) mant++;
        if ((mant >> 24) != 0) begin
          mant = mant >> 1;
          lead++;
        end
      end else begin
        mant = v << (23 - lead);
      end
      be = lead - 30 + half_exp + 127;
      if (be >= 255) return PINF_BITS;
      if (be <= 0) return 32'h0;
      return {1'b0, be[7:0], mant[22:0]};
    endfunction

    function root_expect_t predict_root(logic [31:0] x);
      root_expect_t r;
      logic [7:0] ef;
      logic [22:0] fr;
      logic [23:0] m;
      int e, lead, ue, half_exp;
      longint acc, c;
      longint unsigned p, v, mag, t;
      r.operand = x;
      ef = x[30:23];
      fr = x[22:0];
      if (ef == 8'h00 && fr == 23'h0) begin
        r.root = x;
        r.status = ST_ZERO;
        return r;
      end
      if ((ef == 8'hFF && fr != 23'h0) || x[31]) begin
        r.root = QNAN_BITS;
        r.status = ST_NAN;
        return r;
      end
      if (ef == 8'hFF) begin
        r.root = PINF_BITS;
        r.status = ST_INF;
        return r;
      end
      if (ef == 8'h00) begin
        // Subnormal: move the leading one out to the hidden position.
        lead = 22;
        while (lead > 0 && !fr[lead]) lead--;
        e = lead - 149;
        fr = fr << (23 - lead);
      end else begin
        e = int'(ef) - 127;
      end
      m = {fr, 1'b0};
      acc = coef_q30[0];
      p = m;
      for (int i = 1; i < POLY_TERMS_DEF && i < 16; i++) begin
        c = coef_q30[i];
        mag = (c < 0) ? -c : c;
        t = (mag * p + (64'd1 << 23)) >> 24;
        acc = (c < 0) ? acc - longint'(t) : acc + longint'(t);
        p = (p * m + (64'd1 << 23)) >> 24;
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
      v = acc;
      ue = e + 160;
      if (ue % 2 != 0) v = (v * 64'd1518500250 + (64'd1 << 29)) >> 30;
      half_exp = (ue / 2) - 80;
      r.root = pack_root(v, half_exp);
      r.status = ST_NORMAL;
      return r;
    endfunction

    function void note_operand(logic [31:0] x);
      pending.push_back(predict_root(x));
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(logic [31:0] root, logic [1:0] status);
      root_expect_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat root %h status %0d", root, status));
        return;
      end
      want = pending.pop_front();
      if (root !== want.root)
        report_mismatch($sformatf("operand %h: root %h, want %h",
                                  want.operand, root, want.root));
      if (status !== want.status)
        report_mismatch($sformatf("operand %h: status %0d, want %0d",
                                  want.operand, status, want.status));
    endtask
  endclass

  localparam logic [31:0] EDGE_OPERANDS [23] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'hBF80_0000,
    32'h8000_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000,
    32'h0001_2345, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
    32'h4000_0000, 32'h4080_0000, 32'h3F00_0000, 32'h3FFF_FFFF,
    32'h3F7F_FFFF, 32'h7FFF_FFFF, 32'h4F80_0000
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;

  root_scoreboard sb;

  psa_in_if  in_ch ();
  psa_out_if out_ch ();

  poly_sqrt_approx_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_operand(in_ch.operand_bits);
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.root_bits, out_ch.status);
  end

  // Returns at the falling edge after the operand beat was taken.
  task send_operand(input logic [31:0] x);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operand_bits <= x;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    int sel, k;
    logic [22:0] fr;
    sel = $urandom_range(0, 99);
    if (sel < 68) begin
      return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
    end else if (sel < 82) begin
      k = $urandom_range(1, 23);
      fr = 23'($urandom) & 23'((32'd1 << k) - 1);
      if (fr == 23'h0) fr = 23'h1;
      return {9'h000, fr};
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0: return {1'($urandom), 31'h0};
        1: return {1'($urandom), 8'hFF, 23'h0};
        default: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
      endcase
    end else if (sel < 93) begin
      return {1'b1, 31'($urandom)};
    end
    return $urandom;
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int mode;
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.operand_bits = 32'h0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (EDGE_OPERANDS[j]) send_operand(EDGE_OPERANDS[j]);

    for (int i = 0; i < 850; i++) begin
      // Segments of 100 operands switch which side idles; the tail runs flat out.
      if (i % 100 == 0) begin
        mode = $urandom_range(0, 3);
        tx_idle = mode[0];
        rx_idle = mode[1];
      end
      if (i >= 700) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      send_operand(random_operand());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
